@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, masked while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property, checked during reset as well.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/b2y_pkg.sv @@
// ----------------------------------------------------------------------------
// b2y_pkg
// Sizes, fixed-point coefficients and helpers of the BGRA to YUV 4:2:0 block.
// ----------------------------------------------------------------------------
package b2y_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int CFG_W      = 13;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int CNT_W      = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
  localparam int SLOT_DEPTH = MAX_WIDTH / 2;
  localparam int SLOT_W     = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;

  localparam logic [CNT_W-1:0] WIDTH_RESET = CNT_W'(640);
  localparam logic [CNT_W-1:0] WIDTH_MIN   = CNT_W'(2);
  localparam logic [CNT_W-1:0] WIDTH_TOP   = CNT_W'(MAX_WIDTH & -2);

  localparam int PIX_W   = 8;
  localparam int SUM_W   = PIX_W + 1;
  localparam int ENTRY_W = 3 * SUM_W;
  localparam int DATA_W  = 3 * PIX_W;
  localparam int ACC_W   = 24;
  localparam int FRAC_W  = 15;

  localparam logic [ACC_W-1:0] Y_B   = ACC_W'(3211);
  localparam logic [ACC_W-1:0] Y_G   = ACC_W'(16515);
  localparam logic [ACC_W-1:0] Y_R   = ACC_W'(8421);
  localparam logic [ACC_W-1:0] Y_OFS = ACC_W'(540672);
  localparam logic [ACC_W-1:0] C_OFS = ACC_W'(4210688);
  localparam logic [ACC_W-1:0] CR_R  = ACC_W'(14385);
  localparam logic [ACC_W-1:0] CR_G  = ACC_W'(12059);
  localparam logic [ACC_W-1:0] CR_B  = ACC_W'(2327);
  localparam logic [ACC_W-1:0] CB_B  = ACC_W'(14385);
  localparam logic [ACC_W-1:0] CB_R  = ACC_W'(4850);
  localparam logic [ACC_W-1:0] CB_G  = ACC_W'(9535);

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [SUM_W-1:0] sum_t;
  typedef logic [ACC_W-1:0] acc_t;

  typedef struct packed {
    pix_t red;
    pix_t green;
    pix_t blue;
  } rgb_t;

  typedef struct packed {
    sum_t red;
    sum_t green;
    sum_t blue;
  } rgb_sum_t;

  function automatic pix_t clamp8(input acc_t v);
    acc_t s;
    s = v >> FRAC_W;
    return (s > acc_t'(255)) ? pix_t'(255) : s[PIX_W-1:0];
  endfunction

  function automatic pix_t avg4(input sum_t a, input sum_t b);
    logic [SUM_W:0] t;
    t = (SUM_W+1)'(a) + (SUM_W+1)'(b) + (SUM_W+1)'(2);
    return t[SUM_W:2];
  endfunction

endpackage

@@ rtl/bgra_to_yuv420_converter.sv @@
// ----------------------------------------------------------------------------
// bgra_to_yuv420_converter
// BT.601 BGRA to YCbCr 4:2:0, one result word per input pixel.
// The three stages lie between input word and output word.
// Throughput: one pixel per cycle while the output is not stalled; the line store has one write and one read.
// Reset (rst, synchronous): pipeline empty, position at column 0 of an even
// row, width 640; the line store is not cleared.
// ----------------------------------------------------------------------------
module bgra_to_yuv420_converter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [b2y_pkg::CFG_W-1:0]     cfg_wr_data,   // line_width
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [b2y_pkg::DATA_W-1:0]    s_axis_tdata,  // blue, green, red
  input  logic                          s_axis_tuser,  // frame_start
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [b2y_pkg::DATA_W-1:0]    m_axis_tdata,  // luma, chroma_blue, chroma_red
  output logic                          m_axis_tuser   // chroma_valid
);

  logic [b2y_pkg::CNT_W-1:0]  width_eff;
  logic [b2y_pkg::CNT_W-1:0]  width_raw;
  logic [b2y_pkg::CNT_W-1:0]  width_next;
  logic [b2y_pkg::COL_W-1:0]  column;
  logic [b2y_pkg::COL_W-1:0]  column_next;
  logic                       row_odd;
  logic                       row_odd_next;
  logic [b2y_pkg::COL_W-1:0]  col_cur;
  logic                       odd_cur;
  logic                       wrap;
  b2y_pkg::rgb_t              held;
  b2y_pkg::rgb_t              pix_in;
  b2y_pkg::rgb_sum_t          sum_in;
  logic [b2y_pkg::SLOT_W-1:0] slot;
  logic                       accept;
  logic                       line_wr;
  logic                       line_rd;
  b2y_pkg::rgb_sum_t          line_q;

  logic                       v1;
  logic                       v2;
  logic                       vo;
  logic                       adv1;
  logic                       adv2;
  logic                       adv3;

  b2y_pkg::rgb_t              pix1;
  b2y_pkg::rgb_sum_t          sum1;
  logic                       cv1;
  b2y_pkg::pix_t              luma2;
  b2y_pkg::rgb_t              avg2;
  logic                       cv2;
  b2y_pkg::acc_t              luma_acc;
  b2y_pkg::acc_t              cr_pos;
  b2y_pkg::acc_t              cr_neg;
  b2y_pkg::acc_t              cb_pos;
  b2y_pkg::acc_t              cb_neg;
  b2y_pkg::pix_t              cr_val;
  b2y_pkg::pix_t              cb_val;

  assign adv3          = !vo || m_axis_tready;
  assign adv2          = !v2 || adv3;
  assign adv1          = !v1 || adv2;
  assign s_axis_tready = adv1;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = vo;

  always_comb begin
    width_raw  = b2y_pkg::CNT_W'({cfg_wr_data[b2y_pkg::CFG_W-1:1], 1'b0});
    width_next = width_raw;
    if (width_raw < b2y_pkg::WIDTH_MIN) begin
      width_next = b2y_pkg::WIDTH_MIN;
    end else if (width_raw > b2y_pkg::WIDTH_TOP) begin
      width_next = b2y_pkg::WIDTH_TOP;
    end
  end

  always_comb begin
    pix_in       = b2y_pkg::rgb_t'(s_axis_tdata);
    col_cur      = s_axis_tuser ? '0 : column;
    odd_cur      = s_axis_tuser ? 1'b0 : row_odd;
    wrap         = (b2y_pkg::CNT_W'(col_cur) + b2y_pkg::CNT_W'(1)) >= width_eff;
    column_next  = wrap ? '0 : col_cur + b2y_pkg::COL_W'(1);
    row_odd_next = odd_cur ^ wrap;
    slot         = b2y_pkg::SLOT_W'(col_cur >> 1);
    sum_in.blue  = b2y_pkg::SUM_W'(held.blue) + b2y_pkg::SUM_W'(pix_in.blue);
    sum_in.green = b2y_pkg::SUM_W'(held.green) + b2y_pkg::SUM_W'(pix_in.green);
    sum_in.red   = b2y_pkg::SUM_W'(held.red) + b2y_pkg::SUM_W'(pix_in.red);
    line_wr      = accept && col_cur[0] && !odd_cur;
    line_rd      = accept && col_cur[0] && odd_cur;
  end

  b2y_ram #(
    .WIDTH (b2y_pkg::ENTRY_W),
    .DEPTH (b2y_pkg::SLOT_DEPTH)
  ) u_line (
    .clk     (clk),
    .wr_en   (line_wr),
    .wr_addr (slot),
    .wr_data (sum_in),
    .rd_en   (line_rd),
    .rd_addr (slot),
    .rd_data (line_q)
  );

  always_comb begin
    luma_acc = b2y_pkg::Y_OFS
             + b2y_pkg::acc_t'(pix1.blue) * b2y_pkg::Y_B
             + b2y_pkg::acc_t'(pix1.green) * b2y_pkg::Y_G
             + b2y_pkg::acc_t'(pix1.red) * b2y_pkg::Y_R;
    cr_pos = b2y_pkg::C_OFS + b2y_pkg::acc_t'(avg2.red) * b2y_pkg::CR_R;
    cr_neg = b2y_pkg::acc_t'(avg2.green) * b2y_pkg::CR_G
           + b2y_pkg::acc_t'(avg2.blue) * b2y_pkg::CR_B;
    cb_pos = b2y_pkg::C_OFS + b2y_pkg::acc_t'(avg2.blue) * b2y_pkg::CB_B;
    cb_neg = b2y_pkg::acc_t'(avg2.red) * b2y_pkg::CB_R
           + b2y_pkg::acc_t'(avg2.green) * b2y_pkg::CB_G;
    cr_val = (cr_pos > cr_neg) ? b2y_pkg::clamp8(cr_pos - cr_neg) : '0;
    cb_val = (cb_pos > cb_neg) ? b2y_pkg::clamp8(cb_pos - cb_neg) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_eff <= b2y_pkg::WIDTH_RESET;
      column    <= '0;
      row_odd   <= 1'b0;
      held      <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      vo        <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        width_eff <= width_next;
      end
      if (accept) begin
        column  <= column_next;
        row_odd <= row_odd_next;
        if (!col_cur[0]) begin
          held <= pix_in;
        end
      end
      if (adv1) begin
        v1 <= accept;
      end
      if (adv2) begin
        v2 <= v1;
      end
      if (adv3) begin
        vo <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pix1 <= pix_in;
      sum1 <= sum_in;
      cv1  <= col_cur[0] && odd_cur;
    end
    if (adv2 && v1) begin
      luma2      <= b2y_pkg::clamp8(luma_acc);
      avg2.blue  <= b2y_pkg::avg4(sum1.blue, line_q.blue);
      avg2.green <= b2y_pkg::avg4(sum1.green, line_q.green);
      avg2.red   <= b2y_pkg::avg4(sum1.red, line_q.red);
      cv2        <= cv1;
    end
    if (adv3 && v2) begin
      m_axis_tdata <= {cv2 ? cr_val : b2y_pkg::pix_t'(0),
                       cv2 ? cb_val : b2y_pkg::pix_t'(0), luma2};
      m_axis_tuser <= cv2;
    end
  end

endmodule

@@ rtl/b2y_ram.sv @@
// ----------------------------------------------------------------------------
// b2y_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module b2y_ram #(
  parameter int WIDTH = 27,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/b2y_checker.sv @@
// ----------------------------------------------------------------------------
// b2y_checker
// Port-level checks of the BGRA to YUV 4:2:0 block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module b2y_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [b2y_pkg::DATA_W-1:0] m_axis_tdata,
  input logic                       m_axis_tuser
);

  `ASSERT_CLK(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "output word changed while stalled")
  `ASSERT_CLK(a_no_chroma_zero, clk, rst, m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[23:8] == 16'd0, "chroma not zero without chroma_valid")
  `ASSERT_CLK(a_luma_range, clk, rst, m_axis_tvalid |-> m_axis_tdata[7:0] >= 8'd16 && m_axis_tdata[7:0] <= 8'd235, "luma outside studio range")
  `ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !m_axis_tvalid, "output valid right after reset")

endmodule

bind bgra_to_yuv420_converter b2y_checker u_b2y_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
